### rtl/loh_pkg.sv
// loh_pkg: shared types and constants for the link open handshake block
// used by every rtl file of the block; no dependencies

package loh_pkg;

   localparam int unsigned FrameLen   = 5;
   localparam int unsigned IdxWidth   = 3;
   localparam int unsigned CsrAddrW   = 5;
   localparam int unsigned CsrDataW   = 32;
   localparam int unsigned ReqDataW   = 8;
   localparam int unsigned ReqUserW   = 2;
   localparam int unsigned RspDataW   = 16;
   localparam int unsigned RspUserW   = 1;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_CONN = 2'd2,
      PH_FAIL = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      RX_HUNT  = 3'd0,
      RX_ADDR  = 3'd1,
      RX_CTRL  = 3'd2,
      RX_CHECK = 3'd3,
      RX_CLOSE = 3'd4
   } rx_state_type;

   // register indexes, byte address is 4 times the index
   localparam logic [2:0] REG_FLAG    = 3'd0;
   localparam logic [2:0] REG_ADDRESS = 3'd1;
   localparam logic [2:0] REG_CONTROL = 3'd2;
   localparam logic [2:0] REG_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_RETRY   = 3'd4;

   // beat positions inside the supervision frame
   localparam logic [IdxWidth-1:0] BEAT_OPEN  = 3'd0;
   localparam logic [IdxWidth-1:0] BEAT_ADDR  = 3'd1;
   localparam logic [IdxWidth-1:0] BEAT_CTRL  = 3'd2;
   localparam logic [IdxWidth-1:0] BEAT_CHECK = 3'd3;
   localparam logic [IdxWidth-1:0] BEAT_CLOSE = 3'd4;

   typedef struct packed {
      logic [7:0]  flag_byte;
      logic [7:0]  address_byte;
      logic [7:0]  control_byte;
      logic [15:0] timeout_ticks;
      logic [2:0]  retry_limit;
   } cfg_type;

   // what one accepted item produces: a frame or a single status beat
   typedef struct packed {
      logic      is_frame;
      phase_type status;
   } desc_type;

endpackage

### rtl/loh_csr.sv
// loh_csr: configuration registers behind the apb-style port
// depends on loh_pkg

module loh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [loh_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [loh_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [loh_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                             csr_pready,
   output loh_pkg::cfg_type                 cfg
);

   loh_pkg::cfg_type cfg_ff;
   loh_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            loh_pkg::REG_FLAG:    cfg_in.flag_byte     = csr_pwdata[7:0];
            loh_pkg::REG_ADDRESS: cfg_in.address_byte  = csr_pwdata[7:0];
            loh_pkg::REG_CONTROL: cfg_in.control_byte  = csr_pwdata[7:0];
            loh_pkg::REG_TIMEOUT: cfg_in.timeout_ticks = csr_pwdata[15:0];
            loh_pkg::REG_RETRY:   cfg_in.retry_limit   = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte     <= 8'd126;
         cfg_ff.address_byte  <= 8'd3;
         cfg_ff.control_byte  <= 8'd3;
         cfg_ff.timeout_ticks <= 16'd3;
         cfg_ff.retry_limit   <= 3'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         loh_pkg::REG_FLAG:    csr_prdata = {24'd0, cfg_ff.flag_byte};
         loh_pkg::REG_ADDRESS: csr_prdata = {24'd0, cfg_ff.address_byte};
         loh_pkg::REG_CONTROL: csr_prdata = {24'd0, cfg_ff.control_byte};
         loh_pkg::REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         loh_pkg::REG_RETRY:   csr_prdata = {29'd0, cfg_ff.retry_limit};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/loh_ctrl.sv
// loh_ctrl: link phase, frame receiver, retry count and timeout timer
// depends on loh_pkg

module loh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  loh_pkg::cmd_type  cmd,
   input  logic [7:0]        rx_byte,
   input  loh_pkg::cfg_type  cfg,
   output loh_pkg::desc_type desc
);

   loh_pkg::phase_type    phase_ff, phase_in;
   loh_pkg::rx_state_type rx_ff, rx_in;
   logic [2:0]            retries_ff, retries_in;
   logic [15:0]           timer_ff, timer_in;
   logic                  armed_ff, armed_in;
   logic [15:0]           reload;
   logic [15:0]           timer_dec;
   logic [7:0]            check_byte;
   logic                  send_frame;

   assign reload     = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign timer_dec  = (timer_ff != 16'd0) ? timer_ff - 16'd1 : 16'd0;
   assign check_byte = cfg.address_byte ^ cfg.control_byte;

   always_comb begin
      phase_in   = phase_ff;
      rx_in      = rx_ff;
      retries_in = retries_ff;
      timer_in   = timer_ff;
      armed_in   = armed_ff;
      send_frame = 1'b0;
      case (cmd)
         loh_pkg::CMD_START: begin
            phase_in   = loh_pkg::PH_WAIT;
            retries_in = 3'd0;
            rx_in      = loh_pkg::RX_HUNT;
            timer_in   = reload;
            armed_in   = 1'b1;
            send_frame = 1'b1;
         end
         loh_pkg::CMD_BYTE: begin
            armed_in = 1'b0;
            timer_in = 16'd0;
            if (phase_ff == loh_pkg::PH_WAIT) begin
               case (rx_ff)
                  loh_pkg::RX_HUNT: begin
                     if (rx_byte == cfg.flag_byte) rx_in = loh_pkg::RX_ADDR;
                  end
                  loh_pkg::RX_ADDR: begin
                     if (rx_byte == cfg.address_byte) rx_in = loh_pkg::RX_CTRL;
                     else if (rx_byte == cfg.flag_byte) rx_in = loh_pkg::RX_ADDR;
                     else rx_in = loh_pkg::RX_HUNT;
                  end
                  loh_pkg::RX_CTRL: begin
                     if (rx_byte == cfg.control_byte) rx_in = loh_pkg::RX_CHECK;
                     else if (rx_byte == cfg.flag_byte) rx_in = loh_pkg::RX_ADDR;
                     else rx_in = loh_pkg::RX_HUNT;
                  end
                  loh_pkg::RX_CHECK: begin
                     if (rx_byte == check_byte) rx_in = loh_pkg::RX_CLOSE;
                     else if (rx_byte == cfg.flag_byte) rx_in = loh_pkg::RX_ADDR;
                     else rx_in = loh_pkg::RX_HUNT;
                  end
                  default: begin
                     // closing flag completes the reply frame
                     if (rx_byte == cfg.flag_byte) phase_in = loh_pkg::PH_CONN;
                     rx_in = loh_pkg::RX_HUNT;
                  end
               endcase
            end
         end
         loh_pkg::CMD_TICK: begin
            if (phase_ff == loh_pkg::PH_WAIT && armed_ff) begin
               timer_in = timer_dec;
               if (timer_dec == 16'd0) begin
                  if (retries_ff >= cfg.retry_limit) begin
                     phase_in = loh_pkg::PH_FAIL;
                     armed_in = 1'b0;
                  end else begin
                     retries_in = retries_ff + 3'd1;
                     timer_in   = reload;
                     armed_in   = 1'b1;
                     send_frame = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= loh_pkg::PH_IDLE;
         rx_ff      <= loh_pkg::RX_HUNT;
         retries_ff <= 3'd0;
         timer_ff   <= 16'd0;
         armed_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         rx_ff      <= rx_in;
         retries_ff <= retries_in;
         timer_ff   <= timer_in;
         armed_ff   <= armed_in;
      end
   end

   assign desc.is_frame = send_frame;
   assign desc.status   = phase_in;

endmodule

### rtl/loh_tx.sv
// loh_tx: result register that plays out a frame beat by beat or one status beat
// depends on loh_pkg

module loh_tx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  loh_pkg::desc_type               desc,
   input  loh_pkg::cfg_type                cfg,
   output logic                            room,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [loh_pkg::RspDataW-1:0]    rsp_tdata,
   output logic [loh_pkg::RspUserW-1:0]    rsp_tuser,
   output logic                            rsp_tlast
);

   logic                          valid_ff, valid_in;
   logic [loh_pkg::IdxWidth-1:0]  idx_ff, idx_in;
   loh_pkg::desc_type             desc_ff;
   logic                          beat_done;
   logic                          final_done;
   logic                          last_beat;
   logic [7:0]                    tx_byte;

   assign last_beat  = !desc_ff.is_frame || (idx_ff == loh_pkg::BEAT_CLOSE);
   assign beat_done  = valid_ff & rsp_tready;
   assign final_done = beat_done & last_beat;
   assign room       = !valid_ff || final_done;

   always_comb begin
      case (idx_ff)
         loh_pkg::BEAT_OPEN:  tx_byte = cfg.flag_byte;
         loh_pkg::BEAT_ADDR:  tx_byte = cfg.address_byte;
         loh_pkg::BEAT_CTRL:  tx_byte = cfg.control_byte;
         loh_pkg::BEAT_CHECK: tx_byte = cfg.address_byte ^ cfg.control_byte;
         default:             tx_byte = cfg.flag_byte;
      endcase
      if (!desc_ff.is_frame) tx_byte = 8'd0;
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = loh_pkg::BEAT_OPEN;
      end else if (final_done) begin
         valid_in = 1'b0;
      end else if (beat_done) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= loh_pkg::BEAT_OPEN;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) desc_ff <= desc;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_beat;
   assign rsp_tdata  = {6'd0, desc_ff.status, tx_byte};
   assign rsp_tuser  = desc_ff.is_frame;

endmodule

### rtl/link_open_handshake.sv
// link_open_handshake: set/ua style link establishment, top level
// an accepted req beat loads the result register, which presents its first rsp beat in the next cycle
// throughput with rsp_tready high: one req beat per cycle for items giving a status beat;
//   a start or a resend plays out five rsp beats, one per cycle, from the result register
// the next req beat is taken in the cycle the final rsp beat of the previous item leaves
// reset: synchronous, active high; registers return to defaults, phase idle, no rsp pending

module link_open_handshake (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [loh_pkg::ReqDataW-1:0]     req_tdata,   // rx_byte[7:0]
   input  logic [loh_pkg::ReqUserW-1:0]     req_tuser,   // cmd[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [loh_pkg::RspDataW-1:0]     rsp_tdata,   // tx_byte[7:0], link_status[9:8]
   output logic [loh_pkg::RspUserW-1:0]     rsp_tuser,   // has_byte[0]
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [loh_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [loh_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [loh_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                             csr_pready
);

   loh_pkg::cfg_type  cfg;
   loh_pkg::desc_type desc;
   loh_pkg::cmd_type  cmd;
   logic              room;
   logic              accept;

   assign req_tready = room;
   assign accept     = req_tvalid & room;
   assign cmd        = loh_pkg::cmd_type'(req_tuser[1:0]);

   loh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   loh_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (cmd),
      .rx_byte (req_tdata[7:0]),
      .cfg     (cfg),
      .desc    (desc)
   );

   loh_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .desc       (desc),
      .cfg        (cfg),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sim/tb_link_open_handshake.sv
// tb_link_open_handshake: self-checking testbench for the set/ua link open block
// drives commands on the req stream, registers over the csr port, checks every rsp beat
// depends on rtl/loh_pkg.sv and rtl/link_open_handshake.sv
`timescale 1ns / 100ps

class handshake_scoreboard;
   typedef struct {
      bit                 has_byte;
      bit [7:0]           tx_byte;
      bit                 is_last;
      loh_pkg::phase_type status;
   } beat_type;

   loh_pkg::cfg_type      cfg;
   loh_pkg::phase_type    phase;
   loh_pkg::rx_state_type rx_state;
   logic [2:0]            retries_used;
   logic [15:0]           ticks_left;
   bit                    timer_armed;
   beat_type              beats_due[$];
   int                    failures;

   function new();
      cfg.flag_byte     = 8'h7e;
      cfg.address_byte  = 8'h03;
      cfg.control_byte  = 8'h03;
      cfg.timeout_ticks = 16'd3;
      cfg.retry_limit   = 3'd3;
      phase        = loh_pkg::PH_IDLE;
      rx_state     = loh_pkg::RX_HUNT;
      retries_used = '0;
      ticks_left   = '0;
      timer_armed  = 1'b0;
      failures     = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [loh_pkg::CsrDataW-1:0] value);
      case (idx)
         loh_pkg::REG_FLAG:    cfg.flag_byte     = value[7:0];
         loh_pkg::REG_ADDRESS: cfg.address_byte  = value[7:0];
         loh_pkg::REG_CONTROL: cfg.control_byte  = value[7:0];
         loh_pkg::REG_TIMEOUT: cfg.timeout_ticks = value[15:0];
         loh_pkg::REG_RETRY:   cfg.retry_limit   = value[2:0];
         default: ;
      endcase
   endfunction

   function void arm_timer();
      // a zero timeout counts as one tick
      ticks_left  = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
      timer_armed = 1'b1;
   endfunction

   function void queue_frame();
      logic [7:0] frame_bytes [loh_pkg::FrameLen];
      beat_type   b;
      frame_bytes[loh_pkg::BEAT_OPEN]  = cfg.flag_byte;
      frame_bytes[loh_pkg::BEAT_ADDR]  = cfg.address_byte;
      frame_bytes[loh_pkg::BEAT_CTRL]  = cfg.control_byte;
      frame_bytes[loh_pkg::BEAT_CHECK] = cfg.address_byte ^ cfg.control_byte;
      frame_bytes[loh_pkg::BEAT_CLOSE] = cfg.flag_byte;
      for (int k = 0; k < loh_pkg::FrameLen; k++) begin
         b.has_byte = 1'b1;
         b.tx_byte  = frame_bytes[k];
         b.is_last  = (k == loh_pkg::FrameLen - 1);
         b.status   = phase;
         beats_due.push_back(b);
      end
   endfunction

   function void queue_status();
      beat_type b;
      b.has_byte = 1'b0;
      b.tx_byte  = 8'h00;
      b.is_last  = 1'b1;
      b.status   = phase;
      beats_due.push_back(b);
   endfunction

   function void receive_byte(logic [7:0] rx);
      logic [7:0] want;
      case (rx_state)
         loh_pkg::RX_ADDR: want = cfg.address_byte;
         loh_pkg::RX_CTRL: want = cfg.control_byte;
         default:          want = cfg.address_byte ^ cfg.control_byte;
      endcase
      if (rx_state == loh_pkg::RX_HUNT) begin
         if (rx == cfg.flag_byte) rx_state = loh_pkg::RX_ADDR;
      end else if (rx_state != loh_pkg::RX_CLOSE) begin
         // the expected field wins over a stray flag
         if (rx == want) rx_state = loh_pkg::rx_state_type'(rx_state + 3'd1);
         else if (rx == cfg.flag_byte) rx_state = loh_pkg::RX_ADDR;
         else rx_state = loh_pkg::RX_HUNT;
      end else begin
         if (rx == cfg.flag_byte) begin
            phase       = loh_pkg::PH_CONN;
            timer_armed = 1'b0;
            ticks_left  = '0;
         end
         rx_state = loh_pkg::RX_HUNT;
      end
   endfunction

   function void take_command(loh_pkg::cmd_type cmd, logic [7:0] rx);
      bit resend;
      resend = 1'b0;
      case (cmd)
         loh_pkg::CMD_START: begin
            phase        = loh_pkg::PH_WAIT;
            retries_used = '0;
            rx_state     = loh_pkg::RX_HUNT;
            arm_timer();
            queue_frame();
         end
         loh_pkg::CMD_BYTE: begin
            timer_armed = 1'b0;
            ticks_left  = '0;
            if (phase == loh_pkg::PH_WAIT) receive_byte(rx);
            queue_status();
         end
         loh_pkg::CMD_TICK: begin
            if (phase == loh_pkg::PH_WAIT && timer_armed) begin
               if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
               if (ticks_left == 16'd0) begin
                  if (retries_used >= cfg.retry_limit) begin
                     phase       = loh_pkg::PH_FAIL;
                     timer_armed = 1'b0;
                  end else begin
                     retries_used = retries_used + 3'd1;
                     arm_timer();
                     resend = 1'b1;
                  end
               end
            end
            if (resend) queue_frame();
            else queue_status();
         end
         default: queue_status();
      endcase
   endfunction

   function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   function void check_beat(logic [loh_pkg::RspDataW-1:0] data,
                            logic [loh_pkg::RspUserW-1:0] user, logic tlast);
      beat_type want;
      if (beats_due.size() == 0) begin
         note_failure($sformatf("unexpected rsp beat: tdata=%h tuser=%b tlast=%b",
            data, user, tlast));
         return;
      end
      want = beats_due.pop_front();
      if (user[0] !== want.has_byte || data[7:0] !== want.tx_byte ||
          tlast !== want.is_last || data[9:8] !== want.status)
         note_failure($sformatf({"rsp mismatch: expected has_byte=%0d tx_byte=%h last=%0d ",
            "status=%0d, got has_byte=%0d tx_byte=%h last=%0d status=%0d"},
            want.has_byte, want.tx_byte, want.is_last, want.status,
            user[0], data[7:0], tlast, data[9:8]));
   endfunction

   function void flush_leftover();
      beat_type want;
      while (beats_due.size() != 0) begin
         want = beats_due.pop_front();
         note_failure($sformatf("missing rsp beat: has_byte=%0d tx_byte=%h status=%0d",
            want.has_byte, want.tx_byte, want.status));
      end
   endfunction
endclass

module tb_link_open_handshake;
   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 200;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [loh_pkg::ReqDataW-1:0] req_tdata   = '0;   // rx_byte[7:0]
   logic [loh_pkg::ReqUserW-1:0] req_tuser   = '0;   // cmd[1:0]
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [loh_pkg::RspDataW-1:0] rsp_tdata;          // tx_byte[7:0], link_status[9:8]
   logic [loh_pkg::RspUserW-1:0] rsp_tuser;          // has_byte[0]
   logic                         rsp_tlast;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [loh_pkg::CsrAddrW-1:0] csr_paddr   = '0;
   logic [loh_pkg::CsrDataW-1:0] csr_pwdata  = '0;
   logic [loh_pkg::CsrDataW-1:0] csr_prdata;
   logic                         csr_pready;

   handshake_scoreboard sb;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   link_open_handshake dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = HoldCycles;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.take_command(loh_pkg::cmd_type'(req_tuser[1:0]), req_tdata[7:0]);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_item(input loh_pkg::cmd_type cmd, input logic [7:0] rx);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // lower valid, then wait for every beat due plus a short margin
   task automatic go_quiet();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (sb.beats_due.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx,
                            input logic [loh_pkg::CsrDataW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] flag, input logic [7:0] addr,
                                 input logic [7:0] ctrl, input logic [15:0] timeout,
                                 input logic [2:0] retry);
      write_csr(loh_pkg::REG_FLAG, {24'd0, flag});
      write_csr(loh_pkg::REG_ADDRESS, {24'd0, addr});
      write_csr(loh_pkg::REG_CONTROL, {24'd0, ctrl});
      write_csr(loh_pkg::REG_TIMEOUT, {16'd0, timeout});
      write_csr(loh_pkg::REG_RETRY, {29'd0, retry});
   endtask

   // bytes that matter to the receiver turn up far more often than chance
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 4))
         0: return sb.cfg.flag_byte;
         1: return sb.cfg.address_byte;
         2: return sb.cfg.control_byte;
         3: return sb.cfg.address_byte ^ sb.cfg.control_byte;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_reply(input int corrupt_pct);
      logic [7:0] reply [loh_pkg::FrameLen];
      reply[loh_pkg::BEAT_OPEN]  = sb.cfg.flag_byte;
      reply[loh_pkg::BEAT_ADDR]  = sb.cfg.address_byte;
      reply[loh_pkg::BEAT_CTRL]  = sb.cfg.control_byte;
      reply[loh_pkg::BEAT_CHECK] = sb.cfg.address_byte ^ sb.cfg.control_byte;
      reply[loh_pkg::BEAT_CLOSE] = sb.cfg.flag_byte;
      for (int k = 0; k < loh_pkg::FrameLen; k++) begin
         if ($urandom_range(0, 99) < corrupt_pct) send_item(loh_pkg::CMD_BYTE, pick_byte());
         else send_item(loh_pkg::CMD_BYTE, reply[k]);
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int span;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // open and answer, sometimes late or garbled
               send_item(loh_pkg::CMD_START, 8'($urandom));
               repeat ($urandom_range(0, 2)) send_item(loh_pkg::CMD_TICK, 8'($urandom));
               if ($urandom_range(0, 3) == 0) send_item(loh_pkg::CMD_BYTE, pick_byte());
               send_reply(12);
            end
            4, 5, 6: begin
               // open and let the timer run through resends toward failure
               send_item(loh_pkg::CMD_START, 8'($urandom));
               span = ((sb.cfg.timeout_ticks == 16'd0) ? 1 : int'(sb.cfg.timeout_ticks))
                      * (int'(sb.cfg.retry_limit) + 2);
               if (span > 40) span = 40;
               repeat ($urandom_range(1, span)) send_item(loh_pkg::CMD_TICK, 8'($urandom));
               if ($urandom_range(0, 1) == 0) send_reply(12);
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  send_item(loh_pkg::cmd_type'($urandom_range(0, 3)), pick_byte());
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 8;
      rsp_idle_pct  = 60;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: flag 7e, address 03, control 03
      send_item(loh_pkg::CMD_NONE, 8'hff);
      send_item(loh_pkg::CMD_BYTE, 8'h00);    // idle, ignored
      send_item(loh_pkg::CMD_TICK, 8'h5a);    // idle, ignored
      send_item(loh_pkg::CMD_START, 8'h00);
      send_item(loh_pkg::CMD_BYTE, 8'h7e);
      send_item(loh_pkg::CMD_BYTE, 8'h03);
      send_item(loh_pkg::CMD_BYTE, 8'h7e);    // stray flag goes back to the address state
      send_item(loh_pkg::CMD_BYTE, 8'h03);
      send_item(loh_pkg::CMD_BYTE, 8'h03);
      send_item(loh_pkg::CMD_BYTE, 8'h00);
      send_item(loh_pkg::CMD_BYTE, 8'h7e);    // connected
      send_item(loh_pkg::CMD_TICK, 8'ha5);
      go_quiet();

      // zero timeout acts as one tick, one retry then failure
      apply_settings(8'h7e, 8'h03, 8'h03, 16'd0, 3'd1);
      send_item(loh_pkg::CMD_START, 8'hff);
      send_item(loh_pkg::CMD_TICK, 8'h00);
      send_item(loh_pkg::CMD_TICK, 8'hff);
      send_item(loh_pkg::CMD_TICK, 8'h00);
      send_item(loh_pkg::CMD_BYTE, 8'hff);
      send_item(loh_pkg::CMD_START, 8'h00);
      send_item(loh_pkg::CMD_START, 8'h00);   // restart while waiting
      send_item(loh_pkg::CMD_BYTE, 8'h55);    // any byte cancels the timer, here a mismatch
      send_item(loh_pkg::CMD_TICK, 8'h00);    // timer not armed
      go_quiet();

      apply_settings(8'h7e, 8'h03, 8'h03, 16'd1, 3'd0);
      send_item(loh_pkg::CMD_START, 8'h00);
      send_item(loh_pkg::CMD_TICK, 8'h00);    // no retries allowed
      go_quiet();

      apply_settings(8'hff, 8'h00, 8'hff, 16'd2, 3'd7);
      run_random(140);
      go_quiet();

      // address equal to the flag
      send_idle_pct = 60;
      rsp_idle_pct  = 8;
      apply_settings(8'h00, 8'h00, 8'h5a, 16'd1, 3'd2);
      run_random(140);
      go_quiet();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom_range(1, 4)), 3'($urandom_range(0, 7)));
      hold_request = 1;
      run_random(120);
      go_quiet();

      apply_settings(8'($urandom), 8'hff, 8'h00, 16'hffff, 3'd7);
      run_random(30);
      go_quiet();
      repeat (8) @(posedge clock);

      sb.flush_leftover();
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

### link_open_handshake.f
rtl/loh_pkg.sv
rtl/loh_csr.sv
rtl/loh_ctrl.sv
rtl/loh_tx.sv
rtl/link_open_handshake.sv
sim/tb_link_open_handshake.sv
